@@ src/dip_pkg.sv @@
// Types, constants and range tables shared by the decimal integer parser.
`default_nettype none

package dip_pkg;

   localparam int MAX_WIDTH = 64;
   localparam int NUMBER_WIDTH = 64;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   localparam logic CSR_SIGNED_MODE  = 1'b0;
   localparam logic CSR_WIDTH_SELECT = 1'b1;

   typedef enum logic [2:0] {
      PHASE_LEAD,
      PHASE_SIGN,
      PHASE_DIGIT,
      PHASE_TRAIL,
      PHASE_ERR
   } phase_type;

   typedef struct packed {
      logic [7:0] char_byte;
      logic       end_of_string;
   } req_word_type;

   typedef struct packed {
      logic                    ok;
      logic [NUMBER_WIDTH-1:0] number;
   } rsp_word_type;

   typedef struct packed {
      logic       signed_mode;
      logic [1:0] width_select;
   } cfg_type;

   typedef struct packed {
      phase_type               phase;
      logic [NUMBER_WIDTH-1:0] magnitude;
      logic                    negative;
   } parse_state_type;

   typedef logic [NUMBER_WIDTH-1:0] limit_table_type [16];
   typedef logic [3:0] digit_table_type [16];

   // largest magnitude allowed for a mode, sign and width code
   function automatic logic [NUMBER_WIDTH-1:0] range_limit(input logic sgn, input logic neg,
                                                           input logic [1:0] wsel);
      int w;
      logic [NUMBER_WIDTH-1:0] half;
      w = 8 << wsel;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      half = NUMBER_WIDTH'(1) << (w - 1);
      if (sgn) begin
         return neg ? half : half - NUMBER_WIDTH'(1);
      end
      return half + (half - NUMBER_WIDTH'(1));
   endfunction

   function automatic limit_table_type build_limits();
      limit_table_type t;
      logic [3:0] idx;
      for (int i = 0; i < 16; i++) begin
         idx = 4'(i);
         t[i] = range_limit(idx[3], idx[2], idx[1:0]);
      end
      return t;
   endfunction

   function automatic limit_table_type build_quotients();
      limit_table_type t;
      logic [3:0] idx;
      for (int i = 0; i < 16; i++) begin
         idx = 4'(i);
         t[i] = range_limit(idx[3], idx[2], idx[1:0]) / 10;
      end
      return t;
   endfunction

   function automatic digit_table_type build_remainders();
      digit_table_type t;
      logic [3:0] idx;
      for (int i = 0; i < 16; i++) begin
         idx = 4'(i);
         t[i] = 4'(range_limit(idx[3], idx[2], idx[1:0]) % 10);
      end
      return t;
   endfunction

   // indexed by {signed_mode, negative, width_select}
   localparam limit_table_type LIMIT_TABLE    = build_limits();
   localparam limit_table_type QUOTIENT_TABLE = build_quotients();
   localparam digit_table_type REMAINDER_TABLE = build_remainders();

endpackage

`default_nettype wire

@@ src/dip_step.sv @@
// One parse step: next string state and end-of-string result for one byte.
`default_nettype none

module dip_step import dip_pkg::*; (
   input  wire cfg_type         cfg,
   input  wire parse_state_type cur,
   input  wire req_word_type    word,
   output parse_state_type      nxt,
   output rsp_word_type         result
);

   logic                    is_ws;
   logic                    is_digit;
   logic                    is_sign;
   logic [3:0]              digit;
   logic                    neg_next;
   logic [3:0]              tbl_idx;
   logic                    overflow;
   logic                    take_digit;
   phase_type               phase_next;
   logic [NUMBER_WIDTH-1:0] mag_next;
   logic [NUMBER_WIDTH-1:0] mag_times_ten;
   logic                    fits;
   logic                    ok;

   assign is_ws    = (word.char_byte >= CHAR_TAB && word.char_byte <= CHAR_CR)
                     || word.char_byte == CHAR_SPACE;
   assign is_digit = word.char_byte >= CHAR_ZERO && word.char_byte <= CHAR_NINE;
   assign is_sign  = word.char_byte == CHAR_PLUS || word.char_byte == CHAR_MINUS;
   assign digit    = 4'(word.char_byte - CHAR_ZERO);

   assign neg_next = (cur.phase == PHASE_LEAD && !is_ws && !is_digit && is_sign
                      && cfg.signed_mode) ? (word.char_byte == CHAR_MINUS) : cur.negative;
   assign tbl_idx  = {cfg.signed_mode, neg_next, cfg.width_select};

   assign overflow = cur.magnitude > QUOTIENT_TABLE[tbl_idx]
                     || (cur.magnitude == QUOTIENT_TABLE[tbl_idx]
                         && digit > REMAINDER_TABLE[tbl_idx]);
   assign take_digit = is_digit && (cur.phase == PHASE_LEAD || cur.phase == PHASE_SIGN
                                    || cur.phase == PHASE_DIGIT);
   assign mag_times_ten = (cur.magnitude << 3) + (cur.magnitude << 1);

   // next phase
   always_comb begin
      phase_next = PHASE_ERR;
      case (cur.phase)
         PHASE_LEAD: begin
            if (is_ws) phase_next = PHASE_LEAD;
            else if (is_digit) phase_next = overflow ? PHASE_ERR : PHASE_DIGIT;
            else if (is_sign && cfg.signed_mode) phase_next = PHASE_SIGN;
         end
         PHASE_SIGN: begin
            if (is_digit) phase_next = overflow ? PHASE_ERR : PHASE_DIGIT;
         end
         PHASE_DIGIT: begin
            if (is_digit) phase_next = overflow ? PHASE_ERR : PHASE_DIGIT;
            else if (is_ws) phase_next = PHASE_TRAIL;
         end
         PHASE_TRAIL: begin
            if (is_ws) phase_next = PHASE_TRAIL;
         end
         default: phase_next = PHASE_ERR;
      endcase
   end

   // magnitude, result and string clear
   always_comb begin
      mag_next = cur.magnitude;
      if (take_digit && !overflow) begin
         mag_next = mag_times_ten + NUMBER_WIDTH'(digit);
      end
      // a digit taken now was already checked against the current range
      fits = (take_digit && !overflow) || cur.magnitude <= LIMIT_TABLE[tbl_idx];
      ok   = (phase_next == PHASE_DIGIT || phase_next == PHASE_TRAIL) && fits
             && !(neg_next && !cfg.signed_mode);
      result.ok     = ok;
      result.number = '0;
      if (ok) begin
         result.number = neg_next ? (NUMBER_WIDTH'(0) - mag_next) : mag_next;
      end
      if (word.end_of_string) begin
         nxt.phase     = PHASE_LEAD;
         nxt.magnitude = '0;
         nxt.negative  = 1'b0;
      end else begin
         nxt.phase     = phase_next;
         nxt.magnitude = mag_next;
         nxt.negative  = neg_next;
      end
   end

endmodule

`default_nettype wire

@@ src/decimal_integer_parser.sv @@
// Top level of the decimal integer parser: input register, parse state, result register.
//
//   channel  direction  handshake              word
//   req      in         req_valid / req_stall  req_word_type (char_byte, end_of_string)
//   rsp      out        rsp_valid / rsp_stall  rsp_word_type (ok, number)
//   csr      in         csr_valid / csr_ready  csr_index, csr_data
//
// One byte per cycle unless an end-marked byte waits on a stalled result. A byte is
// first held in the input register, then the parse step updates the string state;
// the byte with the end mark loads the result register.
// Reset restores signed mode, 64-bit range and an empty string.
// A stalled result holds only a byte with the end mark and the bytes behind it.
`default_nettype none

module decimal_integer_parser import dip_pkg::*; (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  wire req_word_type req_word,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output rsp_word_type      rsp_word,
   input  wire               csr_valid,
   output logic              csr_ready,
   input  wire               csr_index,
   input  wire [1:0]         csr_data
);

   cfg_type         cfg_ff, cfg_in;
   logic            s1_valid_ff, s1_valid_in;
   req_word_type    s1_word_ff, s1_word_in;
   parse_state_type state_ff, state_in;
   logic            out_valid_ff, out_valid_in;
   rsp_word_type    out_word_ff, out_word_in;

   parse_state_type step_next;
   rsp_word_type    step_result;
   logic            out_free;
   logic            s1_adv;
   logic            req_take;

   dip_step u_step (
      .cfg    (cfg_ff),
      .cur    (state_ff),
      .word   (s1_word_ff),
      .nxt    (step_next),
      .result (step_result)
   );

   assign csr_ready = 1'b1;
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign s1_adv    = s1_valid_ff && (!s1_word_ff.end_of_string || out_free);
   assign req_stall = s1_valid_ff && !s1_adv;
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         if (csr_index == CSR_SIGNED_MODE) cfg_in.signed_mode = csr_data[0];
         else if (csr_index == CSR_WIDTH_SELECT) cfg_in.width_select = csr_data;
      end
      s1_valid_in = req_take ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
      s1_word_in  = req_take ? req_word : s1_word_ff;
      state_in    = s1_adv ? step_next : state_ff;
      if (s1_adv && s1_word_ff.end_of_string) begin
         out_valid_in = 1'b1;
         out_word_in  = step_result;
      end else begin
         out_valid_in = rsp_stall ? out_valid_ff : 1'b0;
         out_word_in  = out_word_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.signed_mode  <= 1'b1;
         cfg_ff.width_select <= 2'd3;
         s1_valid_ff         <= 1'b0;
         out_valid_ff        <= 1'b0;
         state_ff.phase      <= PHASE_LEAD;
         state_ff.magnitude  <= '0;
         state_ff.negative   <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_word_ff  <= s1_word_in;
      out_word_ff <= out_word_in;
   end

endmodule

`default_nettype wire
